// ===== sv/iocd_pkg.sv =====
// shared types, constants and helpers for the i/o port contention delay unit
package iocd_pkg;

  // widths of the configuration registers and fields
  localparam int FrameW  = 17;
  localparam int LineW   = 9;
  localparam int AddrW   = 16;
  localparam int OutW    = 5;
  // running t-state count: start plus at most 28
  localparam int CountW  = FrameW + 1;
  localparam int DelayW  = 3;
  localparam int StepsW  = 3;
  localparam int DivCntW = $clog2(CountW + 1);
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  localparam int ContendedColumns = 128;

  localparam logic [FrameW-1:0] FrameReset   = FrameW'(69888);
  localparam logic [FrameW-1:0] FirstReset   = FrameW'(14335);
  localparam logic [LineW-1:0]  LineReset    = LineW'(224);
  localparam logic [LineW-1:0]  DisplayReset = LineW'(192);

  typedef enum logic [1:0] {
    REG_FRAME   = 2'd0,
    REG_FIRST   = 2'd1,
    REG_LINE    = 2'd2,
    REG_DISPLAY = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [FrameW-1:0] frame_tstates;
    logic [FrameW-1:0] first_display_tstate;
    logic [LineW-1:0]  line_tstates;
    logic [LineW-1:0]  display_lines;
  } cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_line;     // 0: reduce modulo frame, 1: split into line and column
    logic pos_from_t;
    logic pos_from_rem;
    logic clr_delay;
    logic set_delay;
    logic advance;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic steps_zero;
    logic frame_zero;
    logic no_window;
    logic div_done;
  } dp_status_t;

  function automatic logic [DelayW-1:0] col_delay(input logic [2:0] col);
    logic [DelayW-1:0] d;
    case (col)
      3'd0:    d = 3'd6;
      3'd1:    d = 3'd5;
      3'd2:    d = 3'd4;
      3'd3:    d = 3'd3;
      3'd4:    d = 3'd2;
      3'd5:    d = 3'd1;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/iocd_cfg_regs.sv =====
// apb configuration registers for the contention delay unit
module iocd_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [iocd_pkg::ApbAddrW-1:0]     paddr,
  input  logic [iocd_pkg::ApbDataW-1:0]     pwdata,
  output logic [iocd_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  output iocd_pkg::cfg_t                    cfg_o
);
  import iocd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_tstates        <= FrameReset;
      cfg_q.first_display_tstate <= FirstReset;
      cfg_q.line_tstates         <= LineReset;
      cfg_q.display_lines        <= DisplayReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME:   cfg_q.frame_tstates        <= pwdata[FrameW-1:0];
        REG_FIRST:   cfg_q.first_display_tstate <= pwdata[FrameW-1:0];
        REG_LINE:    cfg_q.line_tstates         <= pwdata[LineW-1:0];
        REG_DISPLAY: cfg_q.display_lines        <= pwdata[LineW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME:   prdata = ApbDataW'(cfg_q.frame_tstates);
      REG_FIRST:   prdata = ApbDataW'(cfg_q.first_display_tstate);
      REG_LINE:    prdata = ApbDataW'(cfg_q.line_tstates);
      REG_DISPLAY: prdata = ApbDataW'(cfg_q.display_lines);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/iocd_div.sv =====
// restoring divider, one quotient bit per cycle
module iocd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [iocd_pkg::CountW-1:0]   dividend_i,
  input  logic [iocd_pkg::FrameW-1:0]   divisor_i,
  output logic                          done_o,
  output logic [iocd_pkg::CountW-1:0]   quo_o,
  output logic [iocd_pkg::FrameW-1:0]   rem_o
);
  import iocd_pkg::*;

  logic                run_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [CountW-1:0]   dvd_q;   // dividend bits shift out, quotient bits shift in
  logic [FrameW-1:0]   rem_q;
  logic [FrameW-1:0]   dvs_q;
  logic [CountW-1:0]   rem_sh;
  logic [CountW-1:0]   diff;
  logic                fits;

  assign rem_sh = {rem_q, dvd_q[CountW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= DivCntW'(CountW);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q && cnt_q != '0) begin
      dvd_q <= {dvd_q[CountW-2:0], fits};
      rem_q <= fits ? diff[FrameW-1:0] : rem_sh[FrameW-1:0];
    end
  end

  assign done_o = run_q & (cnt_q == '0);
  assign quo_o  = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/iocd_datapath.sv =====
// running t-state count, position reduction and contention delay datapath
module iocd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iocd_pkg::cfg_t                cfg_i,
  input  logic [iocd_pkg::FrameW-1:0]   start_tstate_i,
  input  logic [iocd_pkg::AddrW-1:0]    port_address_i,
  input  logic                          high_byte_contended_i,
  input  iocd_pkg::dp_cmd_t             cmd_i,
  output iocd_pkg::dp_status_t          status_o,
  output logic [iocd_pkg::OutW-1:0]     total_tstates_o,
  output logic [iocd_pkg::OutW-1:0]     contention_tstates_o
);
  import iocd_pkg::*;

  logic [CountW-1:0]  t_q;
  logic [FrameW-1:0]  start_q;
  logic [OutW-1:0]    extra_q;
  logic [CountW-1:0]  pos_q;
  logic [DelayW-1:0]  delay_q;
  logic [StepsW-1:0]  steps_q;
  logic               odd_q;

  logic [CountW-1:0]  first_ext;
  logic [CountW-1:0]  disp_ofs;
  logic [CountW-1:0]  div_dvd;
  logic [FrameW-1:0]  div_dvs;
  logic               div_done;
  logic [CountW-1:0]  div_quo;
  logic [FrameW-1:0]  div_rem;
  logic [1:0]         step_len;
  logic               in_window;
  logic [CountW-1:0]  elapsed;

  assign first_ext = {1'b0, cfg_i.first_display_tstate};
  assign disp_ofs  = pos_q - first_ext;

  // operands for the shared divider
  assign div_dvd = cmd_i.div_line ? disp_ofs : t_q;
  assign div_dvs = cmd_i.div_line ? FrameW'(cfg_i.line_tstates) : cfg_i.frame_tstates;

  iocd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // last step of an even port is C:3, every other contended step is C:1
  assign step_len  = (steps_q == StepsW'(1) && !odd_q) ? 2'd3 : 2'd1;
  assign in_window = (div_quo < CountW'(cfg_i.display_lines)) &&
                     (div_rem < FrameW'(ContendedColumns));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= start_tstate_i;
      odd_q   <= port_address_i[0];
      extra_q <= '0;
      if (high_byte_contended_i) begin
        t_q     <= {1'b0, start_tstate_i};
        steps_q <= port_address_i[0] ? StepsW'(4) : StepsW'(2);
      end else begin
        t_q     <= {1'b0, start_tstate_i} + (port_address_i[0] ? CountW'(4) : CountW'(1));
        steps_q <= port_address_i[0] ? StepsW'(0) : StepsW'(1);
      end
    end else if (cmd_i.advance) begin
      t_q     <= t_q + CountW'(delay_q) + CountW'(step_len);
      extra_q <= extra_q + OutW'(delay_q);
      steps_q <= steps_q - 1'b1;
    end

    if (cmd_i.pos_from_t) begin
      pos_q <= t_q;
    end else if (cmd_i.pos_from_rem) begin
      pos_q <= {1'b0, div_rem};
    end

    if (cmd_i.clr_delay) begin
      delay_q <= '0;
    end else if (cmd_i.set_delay) begin
      delay_q <= in_window ? col_delay(div_rem[2:0]) : '0;
    end
  end

  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.frame_zero = (cfg_i.frame_tstates == '0);
  assign status_o.no_window  = (cfg_i.line_tstates == '0) || (pos_q < first_ext);
  assign status_o.div_done   = div_done;

  assign elapsed              = t_q - {1'b0, start_q};
  assign total_tstates_o      = elapsed[OutW-1:0];
  assign contention_tstates_o = extra_q;

endmodule

// ===== sv/iocd_ctrl.sv =====
// controller that sequences the contended steps of one i/o access
module iocd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  iocd_pkg::dp_status_t  status_i,
  output iocd_pkg::dp_cmd_t     cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import iocd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_ADV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        if (status_i.steps_zero) begin
          state_d = S_DONE;
        end else if (status_i.frame_zero) begin
          cmd_o.pos_from_t = 1'b1;
          state_d          = S_CHK;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_MOD;
        end
      end
      S_MOD: begin
        if (status_i.div_done) begin
          cmd_o.pos_from_rem = 1'b1;
          state_d            = S_CHK;
        end
      end
      S_CHK: begin
        if (status_i.no_window) begin
          cmd_o.clr_delay = 1'b1;
          state_d         = S_ADV;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_line  = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_line = 1'b1;
        if (status_i.div_done) begin
          cmd_o.set_delay = 1'b1;
          state_d         = S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = S_SETUP;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

`ifndef ASSERT_OFF
  a_load_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE)
    else $error("load issued outside idle");
  a_div_start_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !status_i.div_done)
    else $error("divider reported done right after start");
  a_done_after_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> $past(state_q) == S_SETUP)
    else $error("done reached without a finished step sequence");
`endif

endmodule

// ===== sv/io_port_contention_delay_unit.sv =====
// top level of the i/o port contention delay unit
// One i/o access is taken when start_i is high and busy_o is low; its result appears on
// total_tstates_o and contention_tstates_o for the single cycle in which done_o is high, and
// must be captured then. An uncontended odd port goes from setup straight to done. Each
// C step runs up to two divisions on one shared bit-serial divider (position modulo frame
// length, then line and column), so the longest access is the one with four C:1 steps.
// busy_o stays high until the result cycle is over.
module io_port_contention_delay_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [iocd_pkg::FrameW-1:0]       start_tstate_i,
  input  logic [iocd_pkg::AddrW-1:0]        port_address_i,
  input  logic                              high_byte_contended_i,
  output logic                              done_o,
  output logic [iocd_pkg::OutW-1:0]         total_tstates_o,
  output logic [iocd_pkg::OutW-1:0]         contention_tstates_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [iocd_pkg::ApbAddrW-1:0]     paddr,
  input  logic [iocd_pkg::ApbDataW-1:0]     pwdata,
  output logic [iocd_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);
  import iocd_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       accept;

  assign accept = start_i & ~busy_o;

  iocd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iocd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  iocd_datapath u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .start_tstate_i        (start_tstate_i),
    .port_address_i        (port_address_i),
    .high_byte_contended_i (high_byte_contended_i),
    .cmd_i                 (cmd),
    .status_o              (status),
    .total_tstates_o       (total_tstates_o),
    .contention_tstates_o  (contention_tstates_o)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("request accepted but unit not busy");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({1'b0, contention_tstates_o} + 6'd4) <= {1'b0, total_tstates_o})
    else $error("contention exceeds total less fixed cost");
`endif

endmodule
